@@ hw/rtl/lec_pkg.sv @@
package lec_pkg;

  // Field widths fixed by the external interface
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned TOL_W      = 10;
  localparam int unsigned TOL13_W    = 14;
  localparam int unsigned MEMBER_W   = 10;
  localparam int unsigned IDX_OUT_W  = 6;
  localparam int unsigned TOTAL_W    = 7;

  // Relaxed limit is 13/10 of the strict one
  localparam int unsigned RELAX_NUM  = 13;

  localparam logic [TOL_W-1:0]    TOL_RESET   = TOL_W'(40);
  localparam logic [TOL13_W-1:0]  TOL13_RESET = TOL13_W'(40 * RELAX_NUM);
  localparam logic [MEMBER_W-1:0] MEMBER_MAX  = {MEMBER_W{1'b1}};

  typedef struct packed {
    logic               start_frame;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] cluster_index;
    logic                 opened_new;
    logic                 dropped_full;
    logic [MEMBER_W-1:0]  member_total;
    logic [TOTAL_W-1:0]   cluster_total;
  } out_t;

endpackage

@@ hw/rtl/lec_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data
module lec_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/lec_match.sv @@
// Representative vs. segment test, forward and swapped endpoint order.
// Endpoints packed as {ax, ay, bx, by}.
module lec_match #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [lec_pkg::TOL_W-1:0]   tol_i,
  input  logic [lec_pkg::TOL13_W-1:0] tol13_i,
  input  logic [4*COORD_BITS-1:0]     rep_i,
  input  logic [4*COORD_BITS-1:0]     seg_i,
  output logic                        match_o
);

  localparam int unsigned SW = (COORD_BITS > lec_pkg::TOL_W) ? COORD_BITS : lec_pkg::TOL_W;
  localparam int unsigned RW = (COORD_BITS + 4 > lec_pkg::TOL13_W) ?
                               COORD_BITS + 4 : lec_pkg::TOL13_W;

  logic [COORD_BITS-1:0] rax, ray, rbx, rby;
  logic [COORD_BITS-1:0] sax, say, sbx, sby;

  // Endpoint pairs: 0 repA/segA, 1 repB/segB, 2 repB/segA, 3 repA/segB
  logic [COORD_BITS-1:0] px [4];
  logic [COORD_BITS-1:0] py [4];
  logic [COORD_BITS-1:0] qx [4];
  logic [COORD_BITS-1:0] qy [4];
  logic [3:0]            strict_ok;
  logic [3:0]            relax_ok;

  assign {rax, ray, rbx, rby} = rep_i;
  assign {sax, say, sbx, sby} = seg_i;

  assign px[0] = rax;  assign py[0] = ray;  assign qx[0] = sax;  assign qy[0] = say;
  assign px[1] = rbx;  assign py[1] = rby;  assign qx[1] = sbx;  assign qy[1] = sby;
  assign px[2] = rbx;  assign py[2] = rby;  assign qx[2] = sax;  assign qy[2] = say;
  assign px[3] = rax;  assign py[3] = ray;  assign qx[3] = sbx;  assign qy[3] = sby;

  for (genvar p = 0; p < 4; p++) begin : g_pair
    logic [COORD_BITS-1:0] dx, dy;
    logic [RW-1:0]         dx_r, dy_r, dx10, dy10;

    assign dx = (px[p] > qx[p]) ? px[p] - qx[p] : qx[p] - px[p];
    assign dy = (py[p] > qy[p]) ? py[p] - qy[p] : qy[p] - py[p];

    // strict: |d| < tol
    assign strict_ok[p] = (SW'(dx) < SW'(tol_i)) && (SW'(dy) < SW'(tol_i));

    // relaxed: 10*|d| < 13*tol
    assign dx_r = RW'(dx);
    assign dy_r = RW'(dy);
    assign dx10 = (dx_r << 3) + (dx_r << 1);
    assign dy10 = (dy_r << 3) + (dy_r << 1);
    assign relax_ok[p] = (dx10 < RW'(tol13_i)) && (dy10 < RW'(tol13_i));
  end

  assign match_o = (strict_ok[0] && relax_ok[1]) || (relax_ok[0] && strict_ok[1]) ||
                   (strict_ok[2] && relax_ok[3]) || (relax_ok[2] && strict_ok[3]);

endmodule

@@ hw/rtl/line_endpoint_clustering.sv @@
// Line endpoint clustering.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one segment per
// transfer; output channel (out_valid_o/out_ready_i/out_data_o) returns one
// result per segment, in order. The cfg channel writes the strict distance
// tolerance (reset 40) and is always ready; write it only while idle.
// Cluster representatives and member counts sit in two RAMs with registered
// read data. Each segment scans representatives in creation order, one
// RAM read per cycle, stopping at the first match.
// After the input transfer the segment is scanned; the outcome then waits in
// ST_DONE until it can be loaded into the output register. The next segment
// is accepted in the cycle after the result is loaded into the output
// register, so a new segment is never taken while one is still in progress.
// If the receiver stalls, the result waits in the output register while the
// next segment is scanned; that one then waits for the register to free up.
// Reset empties the table (cluster count to zero) and restores the tolerance;
// no RAM clearing pass is needed.
module line_endpoint_clustering #(
  parameter int unsigned MAX_CLUSTERS = 64,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lec_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lec_pkg::out_t              out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lec_pkg::TOL_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_CLUSTERS);
  localparam int unsigned CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned EP_W  = 4 * COORD_BITS;
  localparam int unsigned CW    = lec_pkg::COORD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTERS);

  logic [1:0]                    state_q, state_d;
  logic [EP_W-1:0]               seg_q;
  logic [CNT_W-1:0]              used_q, used_d;
  logic [CNT_W-1:0]              ptr_q, ptr_d;
  logic                          rd_vld_q;
  logic [IDX_W-1:0]              rd_idx_q;
  logic                          hit_q, hit_d;
  logic [IDX_W-1:0]              hit_idx_q, hit_idx_d;
  logic [lec_pkg::MEMBER_W-1:0]  hit_mem_q, hit_mem_d;
  logic [lec_pkg::TOL_W-1:0]     tol_q;
  logic [lec_pkg::TOL13_W-1:0]   tol13_q;
  logic                          out_valid_q, out_valid_d;
  lec_pkg::out_t                 out_q, out_d;

  logic                          in_xfer, cfg_xfer;
  logic                          issue, found_now, scan_end, full, load;
  logic [EP_W-1:0]               ep_rdata;
  logic [lec_pkg::MEMBER_W-1:0]  mem_rdata, mem_wdata, mem_inc;
  logic [IDX_W-1:0]              waddr, raddr;
  logic                          ep_we, mem_we, match;
  logic [lec_pkg::TOL13_W-1:0]   cfg_ext;
  logic [CW+COORD_BITS-1:0]      ax_ext, ay_ext, bx_ext, by_ext;
  logic [IDX_W+lec_pkg::IDX_OUT_W-1:0] idx_ext;
  logic [CNT_W+lec_pkg::TOTAL_W-1:0]   total_ext;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Coordinates taken in their low COORD_BITS bits
  assign ax_ext = {{COORD_BITS{1'b0}}, in_data_i.ax};
  assign ay_ext = {{COORD_BITS{1'b0}}, in_data_i.ay};
  assign bx_ext = {{COORD_BITS{1'b0}}, in_data_i.bx};
  assign by_ext = {{COORD_BITS{1'b0}}, in_data_i.by};

  // Tolerance register and its 13x scaled copy
  assign cfg_ext = lec_pkg::TOL13_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= lec_pkg::TOL_RESET;
      tol13_q <= lec_pkg::TOL13_RESET;
    end else if (cfg_xfer) begin
      tol_q   <= cfg_data_i;
      tol13_q <= (cfg_ext << 3) + (cfg_ext << 2) + cfg_ext;
    end
  end

  // Representative and member-count RAMs, read together during the scan
  assign raddr = ptr_q[IDX_W-1:0];

  lec_ram #(
    .WIDTH (EP_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_ep_ram (
    .clk_i   (clk_i),
    .we_i    (ep_we),
    .waddr_i (waddr),
    .wdata_i (seg_q),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (ep_rdata)
  );

  lec_ram #(
    .WIDTH (lec_pkg::MEMBER_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  lec_match #(
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .tol_i   (tol_q),
    .tol13_i (tol13_q),
    .rep_i   (ep_rdata),
    .seg_i   (seg_q),
    .match_o (match)
  );

  // Scan control
  assign found_now = (state_q == ST_SCAN) && rd_vld_q && match;
  assign issue     = (state_q == ST_SCAN) && (ptr_q < used_q) && !found_now;
  assign scan_end  = (state_q == ST_SCAN) && !rd_vld_q && (ptr_q >= used_q);
  assign full      = (used_q == CNT_MAX);
  assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Write-back: bump the hit count or open a new entry
  assign mem_inc   = (hit_mem_q == lec_pkg::MEMBER_MAX) ? hit_mem_q :
                     hit_mem_q + lec_pkg::MEMBER_W'(1);
  assign mem_wdata = hit_q ? mem_inc : lec_pkg::MEMBER_W'(1);
  assign waddr     = hit_q ? hit_idx_q : used_q[IDX_W-1:0];
  assign ep_we     = load && !hit_q && !full;
  assign mem_we    = load && (hit_q || !full);

  // Result assembly
  always_comb begin
    out_d     = out_q;
    used_d    = used_q;
    idx_ext   = '0;
    total_ext = '0;
    if (in_xfer && in_data_i.start_frame) begin
      used_d = '0;
    end
    if (load) begin
      out_d.opened_new   = 1'b0;
      out_d.dropped_full = 1'b0;
      if (hit_q) begin
        idx_ext            = {{lec_pkg::IDX_OUT_W{1'b0}}, hit_idx_q};
        out_d.member_total = mem_inc;
      end else if (!full) begin
        idx_ext            = {{lec_pkg::IDX_OUT_W{1'b0}}, used_q[IDX_W-1:0]};
        out_d.member_total = lec_pkg::MEMBER_W'(1);
        out_d.opened_new   = 1'b1;
        used_d             = used_q + CNT_W'(1);
      end else begin
        out_d.member_total = '0;
        out_d.dropped_full = 1'b1;
      end
      total_ext           = {{lec_pkg::TOTAL_W{1'b0}}, used_d};
      out_d.cluster_index = idx_ext[lec_pkg::IDX_OUT_W-1:0];
      out_d.cluster_total = total_ext[lec_pkg::TOTAL_W-1:0];
    end
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_mem_d   = hit_mem_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SCAN;
          ptr_d   = '0;
          hit_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (found_now) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          hit_mem_d = mem_rdata;
          state_d   = ST_DONE;
        end else if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= issue;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      seg_q <= {ax_ext[COORD_BITS-1:0], ay_ext[COORD_BITS-1:0],
                bx_ext[COORD_BITS-1:0], by_ext[COORD_BITS-1:0]};
    end
    rd_idx_q  <= raddr;
    hit_idx_q <= hit_idx_d;
    hit_mem_q <= hit_mem_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
